// ===== hw/rtl/pbq_pkg.sv =====
// Shared types and constants for the palette block quantizer.
`timescale 1ns / 1ps

package pbq_pkg;

  // Lanes per memory row: entries handled in one cycle of a pixel pass
  localparam int LANES     = 16;
  localparam int LANE_BITS = 4;

  localparam int ENTRY_W = 8;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int COST_W  = 32;
  // Three squared 8-bit channel differences fit in 18 bits
  localparam int DIST_W  = 18;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PIXEL = 1'b1
  } pbq_op_e;

  typedef struct packed {
    pbq_op_e              op;
    logic [ENTRY_W-1:0]   entry_index;
    logic [COLOR_W-1:0]   pixel_color;
    logic                 last_pixel;
  } pbq_in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]   best_index;
    logic [COST_W-1:0]    best_cost;
  } pbq_out_t;

endpackage

// ===== hw/rtl/palette_block_quantizer_top.sv =====
// Palette block quantizer: palette and cost memories with a row-serial pixel pass.
//
// Usage: the input channel (in_valid_i / in_stall_o / in_i) carries two kinds of
// transaction. A write (op = OP_WRITE) loads one palette color;
// indexes at or above PALETTE_SIZE are dropped. A pixel (op = OP_PIXEL) adds
// its squared RGB distance to every entry's saturating 32-bit cost sum. Load
// every palette entry before the first pixel.
// A pixel walks the memories one row of 16 entries per cycle, and the next
// transaction is taken only once the row pass and the read-add-writeback
// pipeline behind it have drained. A pixel marked last_pixel then also loads
// its result onto the output channel (out_valid_o / out_stall_i / out_o): the
// lowest-index entry with the least cost, and that cost. The cost sums then
// read as zero for the next cell.
// Reset clears the control state and marks every cost row as zero; the palette
// holds no defined value until written. A stalled result stays in the output
// register while the next transactions are taken; a later result waits, with
// the input stalled, until the register is free.
`timescale 1ns / 1ps

module palette_block_quantizer_top
  import pbq_pkg::*;
#(
  parameter int PALETTE_SIZE = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pbq_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pbq_out_t out_o
);

  localparam int ROWS     = (PALETTE_SIZE + LANES - 1) / LANES;
  localparam int ROW_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(ROWS - 1);
  localparam logic [COST_W-1:0]   COST_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [ENTRY_W-1:0] idx;
    logic [COST_W-1:0]  cost;
  } cand_t;

  // Squared RGB distance between two colors
  function automatic logic [DIST_W-1:0] color_dist(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
    logic [CHAN_W-1:0]   ca;
    logic [CHAN_W-1:0]   cb;
    logic [CHAN_W-1:0]   d;
    logic [2*CHAN_W-1:0] sq;
    logic [DIST_W-1:0]   acc;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      ca  = a[c*CHAN_W +: CHAN_W];
      cb  = b[c*CHAN_W +: CHAN_W];
      d   = (ca > cb) ? (ca - cb) : (cb - ca);
      sq  = (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
      acc = acc + DIST_W'(sq);
    end
    return acc;
  endfunction

  // Keep the lower-index candidate unless the higher one is strictly cheaper
  function automatic cand_t pick(input cand_t lo, input cand_t hi);
    return (hi.cost < lo.cost) ? hi : lo;
  endfunction

  state_e                   state_q;
  logic [ROW_BITS-1:0]      rd_row_q;
  logic                     last_q;
  logic [COLOR_W-1:0]       color_q;
  logic [ROWS-1:0]          row_valid_q;
  logic                     out_valid_q;
  pbq_out_t                 out_q;

  logic                     s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [ROW_BITS-1:0]      s1_row_q, s2_row_q, s3_row_q, s4_row_q;

  // Memories
  logic [LANES-1:0][COLOR_W-1:0] pal_mem [ROWS];
  logic [LANES-1:0][COST_W-1:0]  cost_mem [ROWS];
  logic [LANES-1:0][COLOR_W-1:0] pal_rd_q;
  logic [LANES-1:0][COST_W-1:0]  cost_rd_q;

  logic [LANES-1:0][DIST_W-1:0]  dist_d, dist_q;
  logic [LANES-1:0][COST_W-1:0]  cost_d, cost_q;
  logic [LANES-1:0][COST_W-1:0]  sum_d, sum_q;
  cand_t                         quad_d [LANES/4];
  cand_t                         quad_q [LANES/4];
  cand_t                         fin_d;
  cand_t                         best_q;

  logic                          in_acc;
  logic                          pal_we;
  logic                          emit_go;
  logic [ROW_BITS-1:0]           wr_row;
  logic [LANE_BITS-1:0]          wr_lane;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Load the result once the output register is free or being taken
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Palette write decode; drop indexes beyond the palette
  assign wr_row  = in_i.entry_index[LANE_BITS +: ROW_BITS];
  assign wr_lane = in_i.entry_index[LANE_BITS-1:0];
  assign pal_we  = in_acc && (in_i.op == OP_WRITE) &&
                   ({1'b0, in_i.entry_index} < (ENTRY_W+1)'(PALETTE_SIZE));

  // Palette memory: one entry written, one row read per cycle
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[wr_row][wr_lane] <= in_i.pixel_color;
    end
    pal_rd_q <= pal_mem[rd_row_q];
  end

  // Cost memory: row read ahead, row written back after the saturating add
  always_ff @(posedge clk_i) begin
    if (s2_vld_q && !last_q) begin
      cost_mem[s2_row_q] <= sum_d;
    end
    cost_rd_q <= cost_mem[rd_row_q];
  end

  // Stage 1: distances per lane; rows not yet written this cell read as zero
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dist_d[l] = color_dist(color_q, pal_rd_q[l]);
      cost_d[l] = row_valid_q[s1_row_q] ? cost_rd_q[l] : '0;
    end
  end

  // Stage 2: saturating accumulate
  always_comb begin
    logic [COST_W:0] s;
    for (int l = 0; l < LANES; l++) begin
      s        = {1'b0, cost_q[l]} + (COST_W+1)'(dist_q[l]);
      sum_d[l] = s[COST_W] ? COST_MAX : s[COST_W-1:0];
    end
  end

  // Stage 3: reduce sixteen lanes to four; lanes past the palette never win
  always_comb begin
    cand_t lvl0 [LANES];
    cand_t lvl1 [LANES/2];
    for (int l = 0; l < LANES; l++) begin
      lvl0[l].idx  = ENTRY_W'({s3_row_q, LANE_BITS'(l)});
      lvl0[l].cost = ((int'(s3_row_q) * LANES + l) >= PALETTE_SIZE) ? COST_MAX : sum_q[l];
    end
    for (int i = 0; i < LANES/2; i++) begin
      lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1]);
    end
    for (int i = 0; i < LANES/4; i++) begin
      quad_d[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    end
  end

  // Stage 4: reduce four to one
  assign fin_d = pick(pick(quad_q[0], quad_q[1]), pick(quad_q[2], quad_q[3]));

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      color_q <= in_i.pixel_color;
    end
    s1_row_q <= rd_row_q;
    s2_row_q <= s1_row_q;
    s3_row_q <= s2_row_q;
    s4_row_q <= s3_row_q;
    dist_q   <= dist_d;
    cost_q   <= cost_d;
    sum_q    <= sum_d;
    quad_q   <= quad_d;
    // Track the running minimum; earlier rows win ties
    if (s4_vld_q && ((s4_row_q == '0) || (fin_d.cost < best_q.cost))) begin
      best_q <= fin_d;
    end
  end

  // Control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_row_q    <= '0;
      last_q      <= 1'b0;
      row_valid_q <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Load a new result, or drop the one just taken
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      s1_vld_q <= (state_q == ST_RUN);
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      // Mark rows written back; the last pixel of a cell clears them
      if (s2_vld_q) begin
        row_valid_q[s2_row_q] <= !last_q;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_i.op == OP_PIXEL)) begin
            state_q  <= ST_RUN;
            rd_row_q <= '0;
            last_q   <= in_i.last_pixel;
          end
        end
        ST_RUN: begin
          if (rd_row_q == ROW_LAST) begin
            state_q <= ST_DRAIN;
          end else begin
            rd_row_q <= rd_row_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (s4_vld_q && (s4_row_q == ROW_LAST)) begin
            state_q <= last_q ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          // Hold until the output register is free
          if (emit_go) begin
            out_q.best_index <= best_q.idx;
            out_q.best_cost  <= best_q.cost;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
